// ===== design/pixel_to_ascii_downsampler_assert.svh =====
`ifndef PIXEL_TO_ASCII_DOWNSAMPLER_ASSERT_SVH
`define PIXEL_TO_ASCII_DOWNSAMPLER_ASSERT_SVH

// Assertion helpers; empty under synthesis.
`ifndef SYNTHESIS
`define P2A_ASSERT(lbl, ck, rn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
		else $error("p2a assertion failed");
`define P2A_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("p2a assertion failed");
`else
`define P2A_ASSERT(lbl, ck, rn, prop)
`define P2A_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif

`endif

// ===== design/p2a_pkg.sv =====
package p2a_pkg;

	localparam int CFG_W = 13;

	localparam logic [1:0] REG_SRC_W = 2'd0;
	localparam logic [1:0] REG_SRC_H = 2'd1;
	localparam logic [1:0] REG_OUT_W = 2'd2;
	localparam logic [1:0] REG_OUT_H = 2'd3;

	localparam logic [7:0] NEWLINE = 8'd10;

	localparam int RST_SRC_W = 640;
	localparam int RST_SRC_H = 480;
	localparam int RST_OUT_W = 80;
	localparam int RST_OUT_H = 40;

	typedef struct packed {
		logic keep;
		logic row_done;
		logic last_row;
	} sel_t;

	function automatic logic [7:0] ramp_char(input logic [3:0] idx);
		logic [7:0] c;
		case (idx)
			4'd0: c = 8'h20;
			4'd1: c = 8'h2E;
			4'd2: c = 8'h3A;
			4'd3: c = 8'h2D;
			4'd4: c = 8'h3D;
			4'd5: c = 8'h2B;
			4'd6: c = 8'h2A;
			4'd7: c = 8'h23;
			4'd8: c = 8'h25;
			default: c = 8'h40;
		endcase
		return c;
	endfunction

	// luma in Q16, then floor(luma*9/255) via (x + (x>>8) + 1) >> 8
	function automatic logic [7:0] luma_char(input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b);
		logic [23:0] acc;
		logic [7:0]  luma;
		logic [11:0] x;
		logic [11:0] t;
		acc  = 24'(r) * 24'd19595 + 24'(g) * 24'd38470 + 24'(b) * 24'd7471;
		luma = acc[23:16];
		x    = 12'(luma) * 12'd9;
		t    = x + 12'(x[11:8]) + 12'd1;
		return ramp_char(t[11:8]);
	endfunction

endpackage

// ===== design/p2a_cfg.sv =====
module p2a_cfg #(
	parameter int MAX_DIM = 4096,
	parameter int DIM_W   = 13
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [3:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             cfg_wr,
	output logic [DIM_W-1:0] src_w,
	output logic [DIM_W-1:0] src_h,
	output logic [DIM_W-1:0] eff_ow,
	output logic [DIM_W-1:0] eff_oh
);

	localparam int RSW = (p2a_pkg::RST_SRC_W > MAX_DIM) ? MAX_DIM : p2a_pkg::RST_SRC_W;
	localparam int RSH = (p2a_pkg::RST_SRC_H > MAX_DIM) ? MAX_DIM : p2a_pkg::RST_SRC_H;
	localparam int ROW = (p2a_pkg::RST_OUT_W > MAX_DIM) ? MAX_DIM : p2a_pkg::RST_OUT_W;
	localparam int ROH = (p2a_pkg::RST_OUT_H > MAX_DIM) ? MAX_DIM : p2a_pkg::RST_OUT_H;

	logic [DIM_W-1:0]          src_w_q, src_h_q, out_w_q, out_h_q;
	logic [p2a_pkg::CFG_W-1:0] wv;
	logic [DIM_W-1:0]          wclamp;
	logic [1:0]                idx;

	assign idx    = paddr[3:2];
	assign cfg_wr = psel & penable & pwrite;
	assign wv     = pwdata[p2a_pkg::CFG_W-1:0];

	always_comb begin
		if (wv == '0) begin
			wclamp = DIM_W'(1);
		end else if (32'(wv) > 32'(MAX_DIM)) begin
			wclamp = DIM_W'(MAX_DIM);
		end else begin
			wclamp = DIM_W'(wv);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= DIM_W'(RSW);
			src_h_q <= DIM_W'(RSH);
			out_w_q <= DIM_W'(ROW);
			out_h_q <= DIM_W'(ROH);
		end else if (cfg_wr) begin
			case (idx)
				p2a_pkg::REG_SRC_W: src_w_q <= wclamp;
				p2a_pkg::REG_SRC_H: src_h_q <= wclamp;
				p2a_pkg::REG_OUT_W: out_w_q <= wclamp;
				p2a_pkg::REG_OUT_H: out_h_q <= wclamp;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			p2a_pkg::REG_SRC_W: prdata = 32'(src_w_q);
			p2a_pkg::REG_SRC_H: prdata = 32'(src_h_q);
			p2a_pkg::REG_OUT_W: prdata = 32'(out_w_q);
			p2a_pkg::REG_OUT_H: prdata = 32'(out_h_q);
			default:            prdata = '0;
		endcase
	end

	assign src_w  = src_w_q;
	assign src_h  = src_h_q;
	assign eff_ow = (out_w_q < src_w_q) ? out_w_q : src_w_q;
	assign eff_oh = (out_h_q < src_h_q) ? out_h_q : src_h_q;

endmodule

// ===== design/p2a_div.sv =====
`include "pixel_to_ascii_downsampler_assert.svh"

module p2a_div #(
	parameter int DIM_W = 13
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIM_W-1:0] dividend,
	input  logic [DIM_W-1:0] divisor,
	output logic             busy,
	output logic [DIM_W-1:0] quotient,
	output logic [DIM_W-1:0] remainder
);

	localparam int CNT_W = $clog2(DIM_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [DIM_W-1:0] quo_q, rem_q;
	logic [DIM_W:0]   shifted, diff;
	logic             ge;

	assign busy    = (cnt_q != '0);
	assign shifted = {rem_q, quo_q[DIM_W-1]};
	assign ge      = (shifted >= {1'b0, divisor});
	assign diff    = shifted - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(DIM_W);
		end else if (busy) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy) begin
			quo_q <= {quo_q[DIM_W-2:0], ge};
			rem_q <= ge ? diff[DIM_W-1:0] : shifted[DIM_W-1:0];
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;

	`P2A_ASSERT_NEXT(a_div_load, clk, arst_n, start, busy)

endmodule

// ===== design/p2a_step.sv =====
module p2a_step #(
	parameter int DIM_W = 13
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             restart,
	input  logic             accept,
	input  logic [DIM_W-1:0] src_w,
	input  logic [DIM_W-1:0] src_h,
	input  logic [DIM_W-1:0] ow,
	input  logic [DIM_W-1:0] oh,
	input  logic [DIM_W-1:0] col_quo,
	input  logic [DIM_W-1:0] col_rem,
	input  logic [DIM_W-1:0] row_quo,
	input  logic [DIM_W-1:0] row_rem,
	output p2a_pkg::sel_t    sel
);

	logic [DIM_W-1:0] src_col_q, src_row_q, out_col_q, out_row_q;
	logic [DIM_W-1:0] nsc_q, crem_q, nsr_q, rrem_q;
	logic [DIM_W:0]   csum, rsum;
	logic             row_kept, col_end, frame_last;

	assign row_kept     = (out_row_q < oh) && (src_row_q == nsr_q);
	assign sel.keep     = row_kept && (out_col_q < ow) && (src_col_q == nsc_q);
	assign sel.row_done = ((DIM_W+1)'(out_col_q) + (DIM_W+1)'(1)) >= (DIM_W+1)'(ow);
	assign sel.last_row = ((DIM_W+1)'(out_row_q) + (DIM_W+1)'(1)) >= (DIM_W+1)'(oh);

	assign csum       = (DIM_W+1)'(crem_q) + (DIM_W+1)'(col_rem);
	assign rsum       = (DIM_W+1)'(rrem_q) + (DIM_W+1)'(row_rem);
	assign col_end    = ((DIM_W+1)'(src_col_q) + (DIM_W+1)'(1)) >= (DIM_W+1)'(src_w);
	assign frame_last = ((DIM_W+1)'(src_row_q) + (DIM_W+1)'(1)) >= (DIM_W+1)'(src_h);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_col_q <= '0;
			src_row_q <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			nsc_q     <= '0;
			crem_q    <= '0;
			nsr_q     <= '0;
			rrem_q    <= '0;
		end else if (restart) begin
			src_col_q <= '0;
			src_row_q <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			nsc_q     <= '0;
			crem_q    <= '0;
			nsr_q     <= '0;
			rrem_q    <= '0;
		end else if (accept) begin
			if (col_end && frame_last) begin
				src_col_q <= '0;
				src_row_q <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
				nsc_q     <= '0;
				crem_q    <= '0;
				nsr_q     <= '0;
				rrem_q    <= '0;
			end else begin
				if (col_end) begin
					src_col_q <= '0;
					src_row_q <= src_row_q + DIM_W'(1);
					out_col_q <= '0;
					nsc_q     <= '0;
					crem_q    <= '0;
				end else begin
					src_col_q <= src_col_q + DIM_W'(1);
					if (sel.keep) begin
						out_col_q <= out_col_q + DIM_W'(1);
						if (csum >= (DIM_W+1)'(ow)) begin
							crem_q <= DIM_W'(csum - (DIM_W+1)'(ow));
							nsc_q  <= nsc_q + col_quo + DIM_W'(1);
						end else begin
							crem_q <= DIM_W'(csum);
							nsc_q  <= nsc_q + col_quo;
						end
					end
				end
				if (sel.keep && sel.row_done) begin
					out_row_q <= out_row_q + DIM_W'(1);
					if (rsum >= (DIM_W+1)'(oh)) begin
						rrem_q <= DIM_W'(rsum - (DIM_W+1)'(oh));
						nsr_q  <= nsr_q + row_quo + DIM_W'(1);
					end else begin
						rrem_q <= DIM_W'(rsum);
						nsr_q  <= nsr_q + row_quo;
					end
				end
			end
		end
	end

endmodule

// ===== design/p2a_emit.sv =====
`include "pixel_to_ascii_downsampler_assert.svh"

module p2a_emit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  logic [7:0]    red,
	input  logic [7:0]    green,
	input  logic [7:0]    blue,
	input  p2a_pkg::sel_t sel,
	output logic          free,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    char_code,
	output logic          run_last,
	output logic          frame_end
);

	logic       valid_s1, row_done_s1, last_row_s1;
	logic [7:0] red_s1, green_s1, blue_s1;
	logic       out_valid_q, last_q, fend_q, nl_pend_q, nl_fend_q;
	logic [7:0] char_q;
	logic       ld, take;

	assign ld   = !out_valid_q || out_ready;
	assign take = ld && !nl_pend_q && valid_s1;
	assign free = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			nl_pend_q   <= 1'b0;
		end else begin
			if (load) begin
				valid_s1 <= 1'b1;
			end else if (take) begin
				valid_s1 <= 1'b0;
			end
			if (ld) begin
				if (nl_pend_q) begin
					out_valid_q <= 1'b1;
					nl_pend_q   <= 1'b0;
				end else if (valid_s1) begin
					out_valid_q <= 1'b1;
					nl_pend_q   <= row_done_s1;
				end else begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			red_s1      <= red;
			green_s1    <= green;
			blue_s1     <= blue;
			row_done_s1 <= sel.row_done;
			last_row_s1 <= sel.last_row;
		end
		if (ld) begin
			if (nl_pend_q) begin
				char_q <= p2a_pkg::NEWLINE;
				last_q <= 1'b1;
				fend_q <= nl_fend_q;
			end else if (valid_s1) begin
				char_q    <= p2a_pkg::luma_char(red_s1, green_s1, blue_s1);
				last_q    <= !row_done_s1;
				fend_q    <= 1'b0;
				nl_fend_q <= last_row_s1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign char_code = char_q;
	assign run_last  = last_q;
	assign frame_end = fend_q;

	`P2A_ASSERT(a_nl_after_char, clk, arst_n, nl_pend_q |-> out_valid_q && !last_q)
	`P2A_ASSERT(a_fend_is_nl, clk, arst_n,
		(out_valid_q && fend_q) |-> (char_q == p2a_pkg::NEWLINE) && last_q)

endmodule

// ===== design/pixel_to_ascii_downsampler.sv =====
// Nearest-neighbor downscaler from a raster RGB pixel stream to ASCII art. Pixels are taken
// one per clock while in_ready is high. Each kept pixel passes an input stage and the output
// register to yield one ramp character; a kept pixel that closes an output row also yields a
// newline, which takes the output register before the next character. Column and row steps
// (source over output size, capped at source size) come from two restoring dividers that run
// after reset and after every register write; the input stays not ready while they run.
`include "pixel_to_ascii_downsampler_assert.svh"

module pixel_to_ascii_downsampler #(
	parameter int MAX_DIM = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  char_code,
	output logic        run_last,
	output logic        frame_end
);

	localparam int DIM_W = $clog2(MAX_DIM + 1);

	logic [DIM_W-1:0] src_w, src_h, eff_ow, eff_oh;
	logic [DIM_W-1:0] col_quo, col_rem, row_quo, row_rem;
	logic             cfg_wr, start_q, cbusy, rbusy, busy, free, accept;
	p2a_pkg::sel_t    sel;

	assign pready = 1'b1;

	p2a_cfg #(.MAX_DIM(MAX_DIM), .DIM_W(DIM_W)) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg_wr  (cfg_wr),
		.src_w   (src_w),
		.src_h   (src_h),
		.eff_ow  (eff_ow),
		.eff_oh  (eff_oh)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 1'b1;
		end else begin
			start_q <= cfg_wr;
		end
	end

	p2a_div #(.DIM_W(DIM_W)) u_div_col (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start_q),
		.dividend  (src_w),
		.divisor   (eff_ow),
		.busy      (cbusy),
		.quotient  (col_quo),
		.remainder (col_rem)
	);

	p2a_div #(.DIM_W(DIM_W)) u_div_row (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start_q),
		.dividend  (src_h),
		.divisor   (eff_oh),
		.busy      (rbusy),
		.quotient  (row_quo),
		.remainder (row_rem)
	);

	assign busy     = start_q | cbusy | rbusy;
	assign in_ready = !busy && free;
	assign accept   = in_valid && in_ready;

	p2a_step #(.DIM_W(DIM_W)) u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (cfg_wr),
		.accept  (accept),
		.src_w   (src_w),
		.src_h   (src_h),
		.ow      (eff_ow),
		.oh      (eff_oh),
		.col_quo (col_quo),
		.col_rem (col_rem),
		.row_quo (row_quo),
		.row_rem (row_rem),
		.sel     (sel)
	);

	p2a_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept && sel.keep),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.sel       (sel),
		.free      (free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.char_code (char_code),
		.run_last  (run_last),
		.frame_end (frame_end)
	);

	`P2A_ASSERT_NEXT(a_wr_blocks_input, clk, arst_n, cfg_wr, !in_ready)

endmodule
